[rtl/core/integer_matrix_multiply_macros.svh]
// Assertion macros for the integer matrix multiply block.
// Every macro expects aclk and aresetn in the scope where it is used.
`ifndef INTEGER_MATRIX_MULTIPLY_MACROS_SVH
`define INTEGER_MATRIX_MULTIPLY_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define IMM_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("integer_matrix_multiply: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define IMM_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("integer_matrix_multiply: next-cycle check failed");

`endif

[rtl/core/imm_pkg.sv]
// Shared types and constants for the integer matrix multiply block.
// No dependencies; imported by imm_ram and integer_matrix_multiply.
`timescale 1ns / 1ps
`default_nettype none

package imm_pkg;

    // Default matrix dimension (rows and columns of A and B).
    localparam int MAX_DIM_DEF = 64;

    // Field widths of the transactions.
    localparam int MODE_W  = 2;
    localparam int IDX_W   = 6;
    localparam int DATA_W  = 8;
    localparam int DIM_W   = 7;
    localparam int PROD_W  = 22;

    // Saturation level of the accumulated product.
    localparam logic [PROD_W-1:0] PROD_MAX = {PROD_W{1'b1}};

    // Operation codes carried in the mode field.
    localparam logic [MODE_W-1:0] MODE_WR_A  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WR_B  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_TAIL,
        ST_FINISH
    } state_t;

endpackage

`default_nettype wire

[rtl/core/imm_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on imm_pkg for its default width and depth.
`timescale 1ns / 1ps
`default_nettype none

module imm_ram
    import imm_pkg::*;
#(
    parameter int WIDTH = DATA_W,
    parameter int DEPTH = MAX_DIM_DEF * MAX_DIM_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[rtl/core/integer_matrix_multiply.sv]
// Integer matrix product, one element of C = A x B per query transaction.
// A write transaction (A or B element) is taken only while idle and gives no result.
// A query makes one read per k from the A and B memories into one multiply-accumulate, with
// n = min(dim_in_use, MAX_DIM) reads, then passes the tail and finish states (finish directly
// when n = 0 or an index is out of range); the next transaction is taken as the result is issued.
// Synchronous active-low reset clears control, sets dim_in_use to 64; memories are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module integer_matrix_multiply
    import imm_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // Configuration write port
    input  wire logic              cfg_we,
    input  wire logic [DIM_W-1:0]  cfg_wdata,
    // Input channel
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [MODE_W-1:0] s_mode,
    input  wire logic [IDX_W-1:0]  s_row,
    input  wire logic [IDX_W-1:0]  s_col,
    input  wire logic [DATA_W-1:0] s_value,
    // Result channel
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [PROD_W-1:0]      m_product
);

`include "integer_matrix_multiply_macros.svh"

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int KW    = $clog2(MAX_DIM + 1);
    localparam int CW    = 10;

    // Registers
    state_t             state_reg, state_next;
    logic [DIM_W-1:0]   dim_reg;
    logic [KW-1:0]      rem_reg, rem_next;
    logic [AW-1:0]      a_addr_reg, a_addr_next;
    logic [AW-1:0]      b_addr_reg, b_addr_next;
    logic [PROD_W-1:0]  acc_reg, acc_next;
    logic               rd_valid_reg, rd_valid_next;
    logic               m_valid_reg, m_valid_next;
    logic [PROD_W-1:0]  m_product_reg, m_product_next;

    // Datapath signals
    logic               rd_en;
    logic               idx_ok;
    logic               in_accept;
    logic               wr_a, wr_b;
    logic [AW-1:0]      wr_addr;
    logic [AW-1:0]      row_base;
    logic [KW-1:0]      n_eff;
    logic [DATA_W-1:0]  a_q, b_q;
    logic [2*DATA_W-1:0] term;
    logic [PROD_W:0]    acc_sum;

    // Index range check, write decode and address formation.
    assign in_accept = s_valid && s_ready;
    assign idx_ok    = (32'(s_row) < MAX_DIM) && (32'(s_col) < MAX_DIM);
    assign wr_a      = in_accept && (s_mode == MODE_WR_A) && idx_ok;
    assign wr_b      = in_accept && (s_mode == MODE_WR_B) && idx_ok;
    assign row_base  = AW'(32'(s_row) * MAX_DIM);
    assign wr_addr   = row_base + AW'(s_col);

    // Dimension in use, saturated to the matrix size.
    assign n_eff = (CW'(dim_reg) > CW'(MAX_DIM)) ? KW'(MAX_DIM) : KW'(dim_reg);

    // Matrix memories.
    imm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram_a (
        .aclk    (aclk),
        .wr_en   (wr_a),
        .wr_addr (wr_addr),
        .wr_data (s_value),
        .rd_en   (rd_en),
        .rd_addr (a_addr_reg),
        .rd_data (a_q)
    );

    imm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram_b (
        .aclk    (aclk),
        .wr_en   (wr_b),
        .wr_addr (wr_addr),
        .wr_data (s_value),
        .rd_en   (rd_en),
        .rd_addr (b_addr_reg),
        .rd_data (b_q)
    );

    // Multiply-accumulate with saturation on the returned element pair.
    assign term    = a_q * b_q;
    assign acc_sum = (PROD_W+1)'(acc_reg) + (PROD_W+1)'(term);

    // Sequencer: next state, memory reads and result hand-off.
    always_comb begin
        state_next     = state_reg;
        rem_next       = rem_reg;
        a_addr_next    = a_addr_reg;
        b_addr_next    = b_addr_reg;
        acc_next       = acc_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_product_next = m_product_reg;
        rd_en          = 1'b0;
        s_ready        = (state_reg == ST_IDLE);

        if (rd_valid_reg) begin
            acc_next = (acc_sum > (PROD_W+1)'(PROD_MAX)) ? PROD_MAX : acc_sum[PROD_W-1:0];
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid && (s_mode == MODE_QUERY)) begin
                    acc_next    = '0;
                    a_addr_next = row_base;
                    b_addr_next = AW'(s_col);
                    rem_next    = n_eff;
                    if (!idx_ok || (n_eff == '0)) begin
                        state_next = ST_FINISH;
                    end else begin
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                rd_en       = 1'b1;
                a_addr_next = a_addr_reg + AW'(1);
                b_addr_next = b_addr_reg + AW'(MAX_DIM);
                rem_next    = rem_reg - KW'(1);
                if (rem_reg == KW'(1)) begin
                    state_next = ST_TAIL;
                end
            end
            ST_TAIL: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_product_next = acc_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rd_valid_next = rd_en;

    // State and control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rd_valid_reg <= rd_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dim_reg <= DIM_W'(64);
        end else if (cfg_we) begin
            dim_reg <= cfg_wdata;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        rem_reg       <= rem_next;
        a_addr_reg    <= a_addr_next;
        b_addr_reg    <= b_addr_next;
        acc_reg       <= acc_next;
        m_product_reg <= m_product_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_product = m_product_reg;

    // Memory writes never overlap a query in flight.
    `IMM_ASSERT_IMP(a_no_write_during_query, wr_a || wr_b, (state_reg == ST_IDLE) && !rd_valid_reg)
    // Read data only returns while the accumulator is collecting it.
    `IMM_ASSERT_NXT(a_read_lands_in_sum, rd_en, (state_reg == ST_RUN) || (state_reg == ST_TAIL))
    // The sequencer never runs with an exhausted term count.
    `IMM_ASSERT_IMP(a_run_has_terms, state_reg == ST_RUN, rem_reg != '0)

endmodule

`default_nettype wire
